>>> sv/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
package swm_pkg;

  localparam int MAX_WIN = 64;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = $clog2(MAX_WIN);
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(3);
  localparam logic [CNT_W-1:0] WIN_MAX   = CNT_W'(MAX_WIN);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [MAX_WIN-1:0]      word_row_t;

  // Contents of one sorting cell as seen by its neighbors
  typedef struct packed {
    logic             vld;
    logic             le;    // value sorts at or below the incoming word
    logic [IDX_W-1:0] age;   // 0 = newest word in the window
    word_t            val;
  } cell_t;

  // Broadcast controls shared by every cell of the row
  typedef struct packed {
    logic             accept;  // input word taken this cycle
    logic             clr;     // restart: treat the row as empty
    logic             flush;   // window length write: empty the row
    logic             evict;   // window full, oldest word leaves
    logic [IDX_W-1:0] w_m1;    // window length minus one
    word_t            v;       // incoming word
    word_t            r;       // value of the word being evicted
  } ctl_t;

  // Left boundary of the row: the incoming word lands at cell 0 if nothing
  // sorts below it
  localparam cell_t HEAD = '{vld: 1'b1, le: 1'b1, age: '0, val: '0};

endpackage

>>> sv/swm_cell.sv
// One cell of the sorted row: holds one window word and its age.
module swm_cell
  import swm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl,
  input  cell_t left_post,   // left neighbor after eviction
  input  cell_t right_raw,   // right neighbor before eviction
  output cell_t raw,
  output cell_t post,
  output word_t evict_val    // own value if this cell is evicted, else zero
);

  logic             vld_r, vld_nxt;
  logic [IDX_W-1:0] age_r, age_nxt;
  word_t            val_r, val_nxt;
  logic             ge;
  logic             rm;

  // Current contents, masked by restart
  always_comb begin
    raw.vld = vld_r & ~ctl.clr;
    raw.age = age_r;
    raw.val = val_r;
    raw.le  = raw.vld & ($signed(val_r) <= $signed(ctl.v));
  end

  // Eviction: the oldest word sorts first among its equals, so every cell
  // at or after it holds a value at or above the evicted one
  always_comb begin
    ge        = ctl.evict & raw.vld & ($signed(val_r) >= $signed(ctl.r));
    rm        = ctl.evict & raw.vld & (age_r == ctl.w_m1);
    evict_val = rm ? val_r : '0;
    post      = ge ? right_raw : raw;
  end

  // Insertion: keep own word, take the incoming word, or shift from the left
  always_comb begin
    if (post.le) begin
      vld_nxt = post.vld;
      age_nxt = post.age + IDX_W'(1);
      val_nxt = post.val;
    end else if (left_post.le) begin
      vld_nxt = 1'b1;
      age_nxt = '0;
      val_nxt = ctl.v;
    end else begin
      vld_nxt = left_post.vld;
      age_nxt = left_post.age + IDX_W'(1);
      val_nxt = left_post.val;
    end
  end

  // Cell registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.flush) begin
      vld_r <= 1'b0;
    end else if (ctl.accept) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      age_r <= age_nxt;
      val_r <= val_nxt;
    end
  end

endmodule

>>> sv/swm_pick.sv
// Median pick from the sorted row and the output register.
module swm_pick
  import swm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             done,      // accepted word yields a median
  input  logic [IDX_W-1:0] mid,
  input  word_row_t        vals,
  input  logic             out_stall,
  output logic             busy,
  output logic             out_valid,
  output word_t            out_median
);

  logic  pend_r, pend_nxt;
  logic  out_valid_r, out_valid_nxt;
  word_t median_r;
  logic  move;

  // A pending median moves once the output register is free
  always_comb begin
    move          = pend_r & (~out_valid_r | ~out_stall);
    busy          = pend_r & ~move;
    pend_nxt      = done | (pend_r & ~move);
    out_valid_nxt = move | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Row already holds the word's result when the pick happens
  always_ff @(posedge clk) begin
    if (move) begin
      median_r <= vals[mid];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = median_r;

endmodule

>>> sv/sliding_window_median.sv
// Top level of the sliding window running median filter.
//
//   channel  signals                          direction
//   in       in_valid in_stall in_sample       word in, in_restart clears window
//            in_restart
//   out      out_valid out_stall out_median    lower median of the full window
//   cfg      cfg_we cfg_window_len             window length, empties window
//
// One word is taken per cycle while in_stall is low; the sorted row of 64 cells
// evicts the oldest word once the window is full and inserts the new one in
// the same cycle. Its median is marked pending as the word enters the row and
// then moves to the out register once that is free; it waits while out is stalled.
// Reset empties the row and sets the window length to 3.
// in_stall rises only while a median waits in the row and out is stalled.
module sliding_window_median
  import swm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  word_t            in_sample,
  input  logic             in_restart,
  output logic             out_valid,
  input  logic             out_stall,
  output word_t            out_median,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_window_len
);

  logic [CNT_W-1:0] win_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] w_eff_m1;
  logic [CNT_W-1:0] fill_eff;
  logic             full;
  logic             accept;
  logic             done;
  logic             busy;
  ctl_t             ctl;
  cell_t            raw  [MAX_WIN];
  cell_t            post [MAX_WIN];
  word_t            evict_val [MAX_WIN];
  word_t            r_val;
  word_row_t        vals;

  // Effective window length, 1..MAX_WIN
  always_comb begin
    if (win_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (win_r > WIN_MAX) begin
      w_eff = WIN_MAX;
    end else begin
      w_eff = win_r;
    end
    w_eff_m1 = w_eff - CNT_W'(1);
  end

  // Fill tracking
  always_comb begin
    accept   = in_valid & ~in_stall;
    fill_eff = in_restart ? '0 : fill_r;
    full     = (fill_eff == w_eff);
    fill_nxt = full ? w_eff : fill_eff + CNT_W'(1);
    done     = accept & (fill_nxt == w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WIN_RESET;
      fill_r <= '0;
    end else if (cfg_we) begin
      win_r  <= cfg_window_len;
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  // Value of the evicted word: at most one cell contributes
  always_comb begin
    r_val = '0;
    for (int i = 0; i < MAX_WIN; i++) begin
      r_val = r_val | evict_val[i];
    end
  end

  always_comb begin
    ctl.accept = accept;
    ctl.clr    = in_restart;
    ctl.flush  = cfg_we;
    ctl.evict  = full;
    ctl.w_m1   = w_eff_m1[IDX_W-1:0];
    ctl.v      = in_sample;
    ctl.r      = r_val;
  end

  // Row of sorting cells
  for (genvar i = 0; i < MAX_WIN; i++) begin : g_cell
    cell_t left_post;
    cell_t right_raw;

    if (i == 0) begin : g_head
      assign left_post = HEAD;
    end else begin : g_mid
      assign left_post = post[i-1];
    end

    if (i == MAX_WIN - 1) begin : g_tail
      assign right_raw = '0;
    end else begin : g_body
      assign right_raw = raw[i+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_post (left_post),
      .right_raw (right_raw),
      .raw       (raw[i]),
      .post      (post[i]),
      .evict_val (evict_val[i])
    );

    assign vals[i] = raw[i].val;
  end

  // Median pick and output register
  swm_pick u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .mid        (w_eff_m1[IDX_W:1]),
    .vals       (vals),
    .out_stall  (out_stall),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_median (out_median)
  );

  assign in_stall = busy;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sliding window running median filter.
module testbench
  import swm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // How a directed row's median is known
  typedef enum logic [1:0] {
    EXP_NONE,  // no median for this word
    EXP_VAL,   // median typed in the table
    EXP_PRED   // median from the filter model
  } exp_kind_e;

  typedef struct packed {
    word_t     smp;
    logic      rs;
    exp_kind_e kind;
    word_t     med;
  } dir_row_t;

  // Receiver stall behavior
  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_RAND,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  localparam word_t MAX_S       = 32'sh7FFF_FFFF;
  localparam word_t MIN_S       = 32'sh8000_0000;
  localparam int    N_DIR       = 25;
  localparam int    N_FIXED     = 10;
  localparam int    N_PHASE     = 12;
  localparam int    PHASE_WORDS = 135;
  localparam int    PHASE_MEDS  = 24;
  localparam int    IDLE_LIMIT  = 2000;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  word_t            in_sample      = '0;
  logic             in_restart     = 1'b0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  word_t            out_median;
  logic             cfg_we         = 1'b0;
  logic [CNT_W-1:0] cfg_window_len = '0;

  // Window length 3 after reset: extremes, duplicates, restarts
  dir_row_t dir_tab [N_DIR] = '{
    '{MAX_S,          1'b1, EXP_NONE, 0},
    '{MIN_S,          1'b0, EXP_NONE, 0},
    '{0,              1'b0, EXP_VAL,  0},
    '{-1,             1'b0, EXP_VAL,  -1},
    '{1,              1'b0, EXP_VAL,  0},
    '{MAX_S,          1'b0, EXP_VAL,  1},
    '{MAX_S,          1'b0, EXP_VAL,  MAX_S},
    '{MIN_S,          1'b0, EXP_VAL,  MAX_S},
    '{5,              1'b1, EXP_NONE, 0},
    '{5,              1'b0, EXP_NONE, 0},
    '{5,              1'b0, EXP_VAL,  5},
    '{7,              1'b0, EXP_VAL,  5},
    '{3,              1'b0, EXP_VAL,  5},
    '{7,              1'b0, EXP_VAL,  7},
    '{9,              1'b0, EXP_VAL,  7},
    '{MIN_S,          1'b1, EXP_NONE, 0},
    '{0,              1'b0, EXP_NONE, 0},
    '{0,              1'b0, EXP_VAL,  0},
    '{32'h5555_5555,  1'b0, EXP_PRED, 0},
    '{32'hAAAA_AAAA,  1'b0, EXP_PRED, 0},
    '{4,              1'b1, EXP_NONE, 0},
    '{-7,             1'b0, EXP_NONE, 0},
    '{-7,             1'b1, EXP_NONE, 0},
    '{2,              1'b0, EXP_NONE, 0},
    '{-3,             1'b0, EXP_VAL,  -3}
  };

  // Window lengths of the first random phases, extremes and out-of-range included
  logic [CNT_W-1:0] fixed_win [N_FIXED] = '{
    7'd0, 7'd1, 7'd127, 7'd2, 7'd64, 7'd65, 7'd3, 7'd4, 7'd7, 7'd5
  };

  // Filter model state
  word_t            ring   [MAX_WIN];
  word_t            ranked [MAX_WIN];
  int unsigned      fill_cnt   = 0;
  int unsigned      oldest     = 0;
  logic [CNT_W-1:0] win_len_q  = WIN_RESET;

  word_t       median_q [$];
  int unsigned err_cnt    = 0;
  int unsigned med_total  = 0;
  int          burst_left = 0;
  int unsigned idle_cnt   = 0;
  stall_mode_e stall_mode = STALL_OFF;
  int          stall_run  = 0;

  sliding_window_median i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median     (out_median),
    .cfg_we         (cfg_we),
    .cfg_window_len (cfg_window_len)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_len(input logic [CNT_W-1:0] len);
    if (len == 0) return 1;
    if (len > WIN_MAX) return MAX_WIN;
    return 32'(len);
  endfunction

  // Append an expected median at the tail of the queue
  function automatic void enqueue_median(input word_t m);
    median_q.insert(median_q.size(), m);
  endfunction

  // Insert into the sorted row holding cnt entries
  function automatic void rank_insert(input word_t smp, input int unsigned cnt);
    int unsigned pos;
    pos = 0;
    while (pos < cnt && ranked[pos] <= smp) pos++;
    for (int unsigned j = cnt; j > pos; j--) ranked[j] = ranked[j-1];
    ranked[pos] = smp;
  endfunction

  // Advance the filter model by one word; returns 1 when a median comes out
  function automatic bit filter_word(input word_t smp, input logic rs, output word_t med);
    int unsigned w;
    int unsigned slot;
    int unsigned pos;
    word_t       old;
    w   = eff_len(win_len_q);
    med = '0;
    if (rs || fill_cnt > w) begin
      fill_cnt = 0;
      oldest   = 0;
    end
    if (fill_cnt < w) begin
      ring[fill_cnt] = smp;
      rank_insert(smp, fill_cnt);
      fill_cnt++;
    end else begin
      slot = oldest % w;
      old  = ring[slot];
      // drop exactly one copy of the evicted value
      pos = 0;
      while (pos < w && ranked[pos] != old) pos++;
      for (int unsigned j = pos; j + 1 < w; j++) ranked[j] = ranked[j+1];
      rank_insert(smp, w - 1);
      ring[slot] = smp;
      oldest     = (slot + 1 == w) ? 0 : slot + 1;
    end
    if (fill_cnt == w) begin
      med = ranked[(w - 1) / 2];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Send one word in bursts with random gaps; called and returns at a falling edge
  task automatic send_word(input word_t smp, input logic rs, input exp_kind_e kind,
                           input word_t med);
    int    gap;
    bit    got;
    word_t pmed;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        7:       gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_sample  <= smp;
    in_restart <= rs;
    do @(posedge clk); while (in_stall);
    got = filter_word(smp, rs, pmed);
    case (kind)
      EXP_VAL:  enqueue_median(med);
      EXP_PRED: if (got) enqueue_median(pmed);
      default:  ;
    endcase
    if (kind == EXP_VAL || (kind == EXP_PRED && got)) med_total++;
    @(negedge clk);
  endtask

  // Window length write once the filter has drained
  task automatic write_window(input logic [CNT_W-1:0] len);
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    // a word with no median may still be in flight
    repeat (4) @(negedge clk);
    cfg_we         <= 1'b1;
    cfg_window_len <= len;
    @(posedge clk);
    win_len_q = len;
    fill_cnt  = 0;
    oldest    = 0;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [CNT_W-1:0] len;
    int unsigned      w;
    int unsigned      n;
    int unsigned      med_start;
    word_t            smp;
    word_t            ramp;
    logic             rs;
    ramp = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_word(dir_tab[i].smp, dir_tab[i].rs, dir_tab[i].kind, dir_tab[i].med);

    for (int p = 0; p < N_PHASE; p++) begin
      len = (p < N_FIXED) ? fixed_win[p] : CNT_W'($urandom_range(0, 127));
      write_window(len);
      w         = eff_len(len);
      n         = 0;
      med_start = med_total;
      while (n < PHASE_WORDS || med_total - med_start < PHASE_MEDS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: smp = word_t'($urandom);
          4, 5, 6:    smp = word_t'($urandom_range(0, 16) - 8);
          7: begin
            case ($urandom_range(0, 3))
              0:       smp = MAX_S;
              1:       smp = MIN_S;
              2:       smp = '0;
              default: smp = -1;
            endcase
          end
          default: begin
            // slowly drifting values, mostly in order
            ramp = ramp + word_t'($urandom_range(0, 6) - 2);
            smp  = ramp;
          end
        endcase
        rs = ($urandom_range(0, 4 * w) == 0);
        send_word(smp, rs, EXP_PRED, '0);
        n++;
      end
    end

    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_run  <= $urandom_range(5, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      STALL_OFF:   out_stall <= 1'b0;
      STALL_RAND:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  // Median checker
  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        $display("%0t: unexpected median word, expected none, actual %0d",
                 $time, out_median);
        err_cnt++;
      end else begin
        want = median_q.pop_front();
        if (out_median !== want) begin
          $display("%0t: median mismatch, expected %0d, actual %0d",
                   $time, want, out_median);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cnt <= 0;
    end else if (idle_cnt == IDLE_LIMIT) begin
      $display("%0t: timeout, %0d medians outstanding", $time, median_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
